### sv/bdd_pkg.sv
// shared types and constants of the block delta dedup table
package bdd_pkg;

	localparam int BLOCK_BYTES = 16;
	localparam int TABLE_SLOTS = 4096;
	localparam int POS_W       = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
	localparam int PAT_W       = 8 * BLOCK_BYTES;
	localparam int SLOT_W      = $clog2(TABLE_SLOTS);
	localparam int CNT_W       = 13;

	typedef struct packed {
		logic [7:0] pixel;
		logic       clear_table;
	} pix_t;

	typedef struct packed {
		logic             pattern_is_new;
		logic             table_full;
		logic [CNT_W-1:0] unique_count;
	} res_t;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [SLOT_W-1:0] addr;
	} mem_req_t;

endpackage

### sv/bdd_pattern.sv
// gathers bytes into a block and builds its delta pattern
module bdd_pattern (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      take,
	input  bdd_pkg::pix_t             pix,
	output logic                      blk_done,
	output logic [bdd_pkg::PAT_W-1:0] pat_q
);
	import bdd_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos;
	logic [7:0]       prev_q;
	logic             last;

	assign pos      = pix.clear_table ? '0 : pos_q;
	assign last     = (pos == POS_W'(BLOCK_BYTES - 1));
	assign blk_done = take && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (take) begin
			pos_q <= last ? '0 : pos + POS_W'(1);
		end
	end

	// entry 0 is zero, later entries are byte minus previous byte
	always_ff @(posedge clk) begin
		if (take) begin
			prev_q <= pix.pixel;
			if (pos == '0) begin
				pat_q <= '0;
			end else begin
				pat_q[8*pos +: 8] <= pix.pixel - prev_q;
			end
		end
	end

endmodule

### sv/bdd_store.sv
// pattern memory, one write and one registered read per cycle
module bdd_store (
	input  logic                      clk,
	input  bdd_pkg::mem_req_t         req,
	input  logic [bdd_pkg::PAT_W-1:0] wdata,
	output logic [bdd_pkg::PAT_W-1:0] rdata_q
);
	import bdd_pkg::*;

	logic [PAT_W-1:0] mem [TABLE_SLOTS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.addr];
		end
	end

endmodule

### sv/bdd_probe.sv
// linear probe sequencer with one shared pattern compare
module bdd_probe (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      clr,
	input  logic [bdd_pkg::CNT_W-1:0] cap,
	input  logic [bdd_pkg::PAT_W-1:0] pat,
	input  logic [bdd_pkg::PAT_W-1:0] rdata,
	input  logic                      post_ok,
	output bdd_pkg::mem_req_t         req,
	output logic                      busy,
	output logic                      res_valid,
	output bdd_pkg::res_t             res
);
	import bdd_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_CMP  = 2'd2;

	logic [1:0]       state_q;
	logic [1:0]       state_d;
	logic [CNT_W-1:0] slot_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] cap_eff;
	logic             hit;
	logic             ins;
	logic             step;

	assign cap_eff = (cap > CNT_W'(TABLE_SLOTS)) ? CNT_W'(TABLE_SLOTS) : cap;
	assign hit     = (rdata == pat);
	assign busy    = (state_q != ST_IDLE);

	always_comb begin
		state_d   = state_q;
		req       = '0;
		req.addr  = slot_q[SLOT_W-1:0];
		res_valid = 1'b0;
		res       = '0;
		ins       = 1'b0;
		step      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				if (slot_q >= cap_eff) begin
					res.table_full   = 1'b1;
					res.unique_count = count_q;
					if (post_ok) begin
						res_valid = 1'b1;
						state_d   = ST_IDLE;
					end
				end else if (slot_q >= count_q) begin
					res.pattern_is_new = 1'b1;
					res.unique_count   = count_q + CNT_W'(1);
					if (post_ok) begin
						res_valid = 1'b1;
						ins       = 1'b1;
						req.we    = 1'b1;
						state_d   = ST_IDLE;
					end
				end else begin
					req.re  = 1'b1;
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				if (hit) begin
					res.unique_count = count_q;
					if (post_ok) begin
						res_valid = 1'b1;
						state_d   = ST_IDLE;
					end
				end else begin
					step    = 1'b1;
					state_d = ST_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (start) begin
				slot_q <= '0;
			end else if (step) begin
				slot_q <= slot_q + CNT_W'(1);
			end
			if (clr) begin
				count_q <= '0;
			end else if (ins) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

endmodule

### sv/block_delta_dedup_table_core.sv
// top level of the block delta dedup table
//
// channel  signals                        moves
// pix      pix_valid / pix_ready / pix    one image byte and clear flag
// res      res_valid / res_ready / res    one result per completed block
// cfg      cfg_valid / cfg_ready / cfg_data  table capacity write
//
// a byte that does not complete a block is taken without a probe walk
// a completing byte starts a probe walk from slot 0: each stored slot is
// compared by a memory read state then a compare state; a hit is reported
// in the compare state, and an insert or full report comes from the read
// state after the last miss
// pix_ready is low while the probe walk runs; the walk holds at its last
// step while the result register is still occupied
// reset empties the table through the fill count, no clearing pass needed
module block_delta_dedup_table_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      pix_valid,
	output logic                      pix_ready,
	input  bdd_pkg::pix_t             pix,
	output logic                      res_valid,
	input  logic                      res_ready,
	output bdd_pkg::res_t             res,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [bdd_pkg::CNT_W-1:0] cfg_data
);
	import bdd_pkg::*;

	logic             take;
	logic             blk_done;
	logic [PAT_W-1:0] pat;
	logic [PAT_W-1:0] rdata;
	mem_req_t         req;
	logic             busy;
	logic             post_ok;
	logic             res_new;
	res_t             res_d;
	logic [CNT_W-1:0] cap_q;
	logic             res_valid_q;
	res_t             res_q;

	// capacity register, writes accepted any time
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CNT_W'(4096);
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	// input side: bytes taken only while no probe walk runs
	assign pix_ready = !busy;
	assign take      = pix_valid && pix_ready;

	bdd_pattern u_pattern (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.pix      (pix),
		.blk_done (blk_done),
		.pat_q    (pat)
	);

	bdd_store u_store (
		.clk     (clk),
		.req     (req),
		.wdata   (pat),
		.rdata_q (rdata)
	);

	// result register frees when empty or being taken this cycle
	assign post_ok = !res_valid_q || res_ready;

	bdd_probe u_probe (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (blk_done),
		.clr       (take && pix.clear_table),
		.cap       (cap_q),
		.pat       (pat),
		.rdata     (rdata),
		.post_ok   (post_ok),
		.req       (req),
		.busy      (busy),
		.res_valid (res_new),
		.res       (res_d)
	);

	// output register between the probe walk and the result transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_new) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_new) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// no byte transfer while a probe walk runs
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !pix_ready)
		else $error("byte taken during probe walk");

	// a result is never both new and full
	a_new_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.pattern_is_new && res.table_full))
		else $error("result both new and full");

	// stored count never passes the table size
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.unique_count <= CNT_W'(TABLE_SLOTS)))
		else $error("unique count beyond table size");

	// a new result is only loaded when the register is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |-> !res_new)
		else $error("pending result overwritten");

endmodule
